>>> rtl/wbss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wbss_pkg;

  // Capacity of the pattern registers, in byte positions
  localparam int REG_CAP = 16;
  localparam int LEN_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W = 2;
  localparam int OUT_OFFSET_W = 32;

  // Register indexes, at byte address 8*index
  localparam logic [REG_IDX_W-1:0] REG_PAT_LO = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_HI = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WILD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEN = 2'd3;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

  typedef logic [REG_CAP-1:0][7:0] pattern_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic                    found;
    logic [OUT_OFFSET_W-1:0] match_offset;
  } out_word_t;

  // Shared control handed to every cell of the window
  typedef struct packed {
    logic             shift;
    logic             clear;
    logic [LEN_W-1:0] len;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/wbss_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module wbss_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wbss_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wbss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wbss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output wbss_pkg::pattern_t                   pattern,
  output logic      [wbss_pkg::REG_CAP-1:0]    wild_mask,
  output logic      [wbss_pkg::LEN_W-1:0]      pat_len
);
  import wbss_pkg::*;

  logic [63:0]        pat_lo_r;
  logic [63:0]        pat_hi_r;
  logic [REG_CAP-1:0] wild_r;
  logic [LEN_W-1:0]   len_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      wild_r   <= '0;
      len_r    <= LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAT_LO: pat_lo_r <= pwdata;
        REG_PAT_HI: pat_hi_r <= pwdata;
        REG_WILD:   wild_r   <= pwdata[REG_CAP-1:0];
        REG_LEN:    len_r    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_PAT_LO: prdata = pat_lo_r;
      REG_PAT_HI: prdata = pat_hi_r;
      REG_WILD:   prdata = CFG_DATA_W'(wild_r);
      REG_LEN:    prdata = CFG_DATA_W'(len_r);
      default:    prdata = '0;
    endcase
  end

  assign pattern   = {pat_hi_r, pat_lo_r};
  assign wild_mask = wild_r;
  assign pat_len   = len_r;

endmodule

`default_nettype wire

>>> rtl/wbss_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wbss_cell #(
  parameter int IDX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire wbss_pkg::cell_ctl_t          ctl,
  input  wire wbss_pkg::pattern_t           pattern,
  input  wire logic [wbss_pkg::REG_CAP-1:0] wild_mask,
  input  wire logic [7:0]                   byte_in,
  output logic      [7:0]                   byte_out,
  output logic                              pos_ok
);
  import wbss_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // Take the neighbor's byte on a shift, drop the window at region end
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = ctl.clear ? 8'd0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

  // Compare the incoming byte against the position it stands for
  generate
    if (IDX < REG_CAP) begin : g_cmp
      logic [LEN_W-1:0] pos;
      logic             in_use;
      assign in_use = ctl.len > LEN_W'(IDX);
      assign pos    = ctl.len - LEN_W'(1) - LEN_W'(IDX);
      assign pos_ok = !in_use || wild_mask[pos[3:0]] || (byte_in == pattern[pos[3:0]]);
    end else begin : g_idle
      assign pos_ok = 1'b1;
    end
  endgenerate

endmodule

`default_nettype wire

>>> rtl/wildcard_byte_signature_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready  | data_byte, last_byte
// out     | output    | out_valid / out_ready| found, match_offset
// cfg     | input     | APB psel / penable   | four registers at 8*index
//
// One byte is taken per cycle while in_ready is high; the window shift and the
// masked compare of all positions run in the cycle the byte is accepted, and
// the result is registered into the output stage.
// Reset (rst_n low, synchronous) clears the window, the byte count and the
// pattern and wildcard registers, sets the length to one; no clearing pass is needed.
// A two-entry output stage (output register plus skid) keeps input flowing
// while one result waits; in_ready drops only while both entries are full.

module wildcard_byte_signature_scan #(
  parameter int PATTERN_MAX = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire wbss_pkg::in_word_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output wbss_pkg::out_word_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wbss_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wbss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wbss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import wbss_pkg::*;

  localparam int LEN_CAP = (PATTERN_MAX < REG_CAP) ? PATTERN_MAX : REG_CAP;

  pattern_t           pattern;
  logic [REG_CAP-1:0] wild_mask;
  logic [LEN_W-1:0]   pat_len;
  logic [LEN_W-1:0]   len_eff;

  cell_ctl_t          ctl;
  logic [PATTERN_MAX-1:0][7:0] chain;
  logic [PATTERN_MAX-1:0]      cell_ok;

  logic [OFFSET_BITS-1:0] cnt_r;
  logic [OFFSET_BITS-1:0] cnt_nxt;
  logic [OFFSET_BITS-1:0] cnt_inc;
  logic [OFFSET_BITS-1:0] diff;
  logic                   matched_r;
  logic                   matched_nxt;

  logic      accept;
  logic      hit;
  logic      res_v;
  out_word_t res;

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_word_t main_r, main_nxt;
  out_word_t skid_r, skid_nxt;
  logic      pop;

  wbss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pattern   (pattern),
    .wild_mask (wild_mask),
    .pat_len   (pat_len)
  );

  // Clamp the length to the usable range
  always_comb begin
    if (pat_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len > LEN_W'(LEN_CAP)) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = pat_len;
    end
  end

  assign in_ready  = !skid_v_r;
  assign accept    = in_valid && in_ready;
  assign ctl.shift = accept;
  assign ctl.clear = in_data.last_byte;
  assign ctl.len   = len_eff;

  // Window: one cell per byte, newest byte enters cell 0
  genvar k;
  generate
    for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [7:0] cell_in;
      if (k == 0) begin : g_head
        assign cell_in = in_data.data_byte;
      end else begin : g_body
        assign cell_in = chain[k-1];
      end
      wbss_cell #(.IDX(k)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .pattern   (pattern),
        .wild_mask (wild_mask),
        .byte_in   (cell_in),
        .byte_out  (chain[k]),
        .pos_ok    (cell_ok[k])
      );
    end
  endgenerate

  // Count region bytes, saturating at all ones
  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + OFFSET_BITS'(1);
  assign diff    = cnt_inc - OFFSET_BITS'(len_eff);
  assign hit     = (&cell_ok) && (cnt_inc >= OFFSET_BITS'(len_eff));

  always_comb begin
    res_v            = accept && !matched_r && (hit || in_data.last_byte);
    res.found        = hit;
    res.match_offset = hit ? OUT_OFFSET_W'(diff) : '0;
    cnt_nxt          = cnt_r;
    matched_nxt      = matched_r;
    if (accept) begin
      if (in_data.last_byte) begin
        cnt_nxt     = '0;
        matched_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_inc;
        if (hit) begin
          matched_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      matched_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      matched_r <= matched_nxt;
    end
  end

  // Output register with skid: hold, advance or fill
  assign pop = main_v_r && out_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r) begin
      main_v_nxt = res_v;
      main_nxt   = res;
    end else if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = res_v;
        main_nxt   = res;
      end
    end else if (res_v) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // A waiting skid entry always sits behind a valid output word
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without output word");

  // A not-found word carries a zero offset
  a_nf_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.match_offset == '0))
    else $error("not-found word with nonzero offset");

  // A region byte after a reported match gives no word
  a_no_word_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && matched_r) |-> !res_v)
    else $error("word produced after match was reported");

  // The count advances by one on an inner byte until it saturates
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_data.last_byte && !(&cnt_r)) |=> (cnt_r == $past(cnt_r) + OFFSET_BITS'(1)))
    else $error("byte count did not advance");

endmodule

`default_nettype wire

>>> tb/wbss_scan_checker.sv
`timescale 1ns / 1ps

// Watches the byte and result channels and the register port, keeps its own
// copy of the signature settings and the scan window, and checks every result
// word against the oldest predicted one.
module wbss_scan_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire wbss_pkg::in_word_t              in_data,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire wbss_pkg::out_word_t             out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wbss_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wbss_pkg::CFG_DATA_W-1:0] pwdata,
  input  wire logic                            pready,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   results_seen
);
  import wbss_pkg::*;

  // Shadow copy of the signature registers
  logic [2*CFG_DATA_W-1:0] sig_bytes;
  logic [REG_CAP-1:0]      wild_bits;
  logic [LEN_W-1:0]        sig_len_reg;

  // Scan state: entry 0 holds the newest byte
  logic [7:0]              scan_window [REG_CAP];
  logic [OUT_OFFSET_W-1:0] bytes_seen;
  logic                    hit_done;

  out_word_t expected_hits [$];
  int        errors;
  int        checked;

  function automatic int unsigned active_len();
    int unsigned n;
    n = sig_len_reg;
    if (n == 0) n = 1;
    if (n > REG_CAP) n = REG_CAP;
    return n;
  endfunction

  // Masked compare: position p sits n-1-p bytes back from the newest
  function automatic bit window_hit(int unsigned n);
    for (int p = 0; p < n; p++) begin
      if (!wild_bits[p] && scan_window[n-1-p] != sig_bytes[p*8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    foreach (scan_window[k]) scan_window[k] = 8'h00;
    bytes_seen = '0;
    hit_done = 1'b0;
  endtask

  // Shift one byte in and queue the result word it causes, if any
  task automatic predict_byte(input in_word_t w);
    int unsigned n;
    out_word_t   r;
    n = active_len();
    for (int k = REG_CAP - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
    scan_window[0] = w.data_byte;
    if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
    if (!hit_done) begin
      if (bytes_seen >= n && window_hit(n)) begin
        hit_done = 1'b1;
        r.found = 1'b1;
        r.match_offset = bytes_seen - OUT_OFFSET_W'(n);
        expected_hits.push_back(r);
      end else if (w.last_byte) begin
        r.found = 1'b0;
        r.match_offset = '0;
        expected_hits.push_back(r);
      end
    end
    if (w.last_byte) clear_scan();
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    checked++;
    if (expected_hits.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected: found %0b offset %0d",
               $time, got.found, got.match_offset);
    end else begin
      want = expected_hits.pop_front();
      if (got.found !== want.found) begin
        errors++;
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
      end
      if (got.match_offset !== want.match_offset) begin
        errors++;
        $display("%0t: match_offset expected %0d actual %0d",
                 $time, want.match_offset, got.match_offset);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] val);
    logic [REG_IDX_W-1:0] idx;
    idx = addr[CFG_ADDR_W-1:3];
    case (idx)
      REG_PAT_LO: sig_bytes[CFG_DATA_W-1:0] = val;
      REG_PAT_HI: sig_bytes[2*CFG_DATA_W-1:CFG_DATA_W] = val;
      REG_WILD:   wild_bits = val[REG_CAP-1:0];
      REG_LEN:    sig_len_reg = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Output words first: a byte taken at this edge can only answer later
  always @(posedge clk) begin
    if (!rst_n) begin
      sig_bytes = '0;
      wild_bits = '0;
      sig_len_reg = LEN_RESET;
      clear_scan();
      expected_hits.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_byte(in_data);
      if (psel && penable && pwrite && pready) write_reg(paddr, pwdata);
    end
    pending <= expected_hits.size();
    fail_count <= errors;
    results_seen <= checked;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wbss_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  in_word_t              in_data = '0;
  logic                  out_ready = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;

  logic                  in_ready;
  logic                  out_valid;
  out_word_t             out_data;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int results_seen;

  // Stimulus-side view of the current signature, used to plant matches
  logic [7:0]         stim_pat [REG_CAP];
  logic [REG_CAP-1:0] stim_wild = '0;
  int unsigned        stim_len = 1;
  logic               idle_on = 1'b1;
  int unsigned        stall_left = 0;
  int                 n_bytes = 0;
  int                 n_regions = 0;
  int                 n_settings = 0;

  wildcard_byte_signature_scan dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wbss_scan_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side in random bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Setup then access phase; psel stays up across back-to-back writes
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_setting(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [REG_CAP-1:0] wild, input logic [LEN_W-1:0] len);
    apb_write(REG_PAT_LO, lo);
    apb_write(REG_PAT_HI, hi);
    apb_write(REG_WILD, CFG_DATA_W'(wild));
    apb_write(REG_LEN, CFG_DATA_W'(len));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < REG_CAP; p++) stim_pat[p] = (p < 8) ? lo[p*8 +: 8] : hi[(p-8)*8 +: 8];
    stim_wild = wild;
    stim_len = (len == 0) ? 1 : (len > REG_CAP) ? REG_CAP : len;
    n_settings++;
  endtask

  // Present one byte word, sometimes with a random gap ahead of it, and hold until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
    n_bytes++;
    if (last) n_regions++;
  endtask

  // Drop valid, let every predicted word come back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Filler: half fully random, half bytes of the signature for near misses
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom);
    return stim_pat[$urandom_range(0, stim_len - 1)];
  endfunction

  task automatic random_setting();
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic [REG_CAP-1:0] w;
    logic [LEN_W-1:0]   n;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: begin
        lo = '0;
        hi = '0;
      end
      1: begin
        lo = '1;
        hi = '1;
      end
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      2: w = REG_CAP'($urandom);
      default: w = REG_CAP'($urandom & $urandom & $urandom);
    endcase
    case ($urandom_range(0, 9))
      0: n = '0;
      1: n = 5'd1;
      2: n = 5'd16;
      3: n = LEN_W'($urandom_range(17, 31));
      default: n = LEN_W'($urandom_range(2, 8));
    endcase
    load_setting(lo, hi, w, n);
  endtask

  // One region: mostly a planted signature, some corrupted, some pure filler
  task automatic random_region();
    int unsigned kind;
    int unsigned lead;
    int unsigned total;
    logic [7:0]  seg [REG_CAP];
    logic [7:0]  b;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      total = $urandom_range(1, 24);
      for (int i = 0; i < total; i++) send_byte(noise_byte(), i == total - 1);
    end else begin
      lead = $urandom_range(0, 10);
      total = lead + stim_len + $urandom_range(0, 6);
      for (int p = 0; p < stim_len; p++) seg[p] = stim_wild[p] ? 8'($urandom) : stim_pat[p];
      if (kind >= 6) begin
        b = 8'h01 << $urandom_range(0, 7);
        seg[$urandom_range(0, stim_len - 1)] ^= b;
      end
      for (int i = 0; i < total; i++) begin
        b = (i >= lead && i < lead + stim_len) ? seg[i - lead] : noise_byte();
        send_byte(b, i == total - 1);
      end
    end
  endtask

  initial begin
    foreach (stim_pat[p]) stim_pat[p] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one-byte signature 0x00; later bytes after a hit stay quiet
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain();

    // Three positions, middle one wildcard: hit on the final byte, short region,
    // wildcard taking a byte that differs from its pattern byte
    load_setting(64'h0000_0000_0080_FF00, 64'h0, 16'h0002, 5'd3);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // Length zero acts as one
    load_setting(64'h7F, '1, 16'h0000, 5'd0);
    send_byte(8'h7F, 1'b1);
    drain();

    // Length above capacity clamps to sixteen; a short region misses
    load_setting('1, '1, 16'hFFFF, 5'd31);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b1);
    drain();

    // Random settings and regions; the tail of the run has no idling
    while (n_bytes < 800) begin
      idle_on <= (n_bytes < 680) && ($urandom_range(0, 3) != 0);
      random_setting();
      repeat ($urandom_range(3, 8)) random_region();
      drain();
    end

    $display("tb_top: %0d bytes in %0d regions under %0d register settings",
             n_bytes, n_regions, n_settings);
    $display("tb_top: %0d result words compared", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
